// File: src/psq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg: shared types and constants of the priority sorted stack
// Word formats, status codes and the control bundle that the top level
// broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package psq_pkg;

   localparam int DEPTH       = 128;
   localparam int ID_WIDTH    = 16;
   localparam int LEVEL_WIDTH = 3;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_PUSHED    = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_POPPED    = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic                   op;
      logic [ID_WIDTH-1:0]    in_id;
      logic [LEVEL_WIDTH-1:0] in_priority;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [ID_WIDTH-1:0]    out_id;
      logic [LEVEL_WIDTH-1:0] out_priority;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]    id;
      logic [LEVEL_WIDTH-1:0] level;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// File: src/psq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_cell: one storage slot of the sorted stack
// Holds one entry. On a push it keeps its entry, takes the new one or takes
// its upper neighbor's; on a pop it takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module psq_cell (
   input  logic                   clock,
   input  psq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  psq_pkg::entry_type     prev_entry,
   input  logic                   prev_greater,
   input  psq_pkg::entry_type     next_entry,
   output psq_pkg::entry_type     entry,
   output logic                   greater
);
   import psq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Cells holding a strictly larger level form a prefix from the top.
   assign greater = occupied && (entry_ff.level > ctrl.new_entry.level);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!greater) begin
            entry_in = prev_greater ? ctrl.new_entry : prev_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/priority_sorted_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_stack_unit: bounded priority store kept in sorted order
// A row of cells, top first, kept sorted by level with the largest level
// number on top and the newest entry highest among equal levels.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Direction  Flow control
//   request   start, busy, req_data          in         start and not busy
//   response  rsp_valid, rsp_data            out        one-cycle strobe
//
// All cells shift or hold in parallel at the edge that accepts a word, so
// busy stays low and a word can be sent in every cycle.
// The response appears in the cycle after acceptance, for one cycle.
// Synchronous reset empties the store; cell contents are not cleared.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module priority_sorted_stack_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  psq_pkg::req_type req_data,
   output logic             rsp_valid,
   output psq_pkg::rsp_type rsp_data
);
   import psq_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   accept;
   logic                   full;
   logic                   empty;
   cell_ctrl_type          ctrl;
   entry_type              cell_entry [DEPTH];
   logic                   cell_greater [DEPTH];

   // Each word completes in the cycle it is accepted.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctrl.push            = accept && (req_data.op == OP_PUSH) && !full;
   assign ctrl.pop             = accept && (req_data.op == OP_POP) && !empty;
   assign ctrl.new_entry.id    = req_data.in_id;
   assign ctrl.new_entry.level = req_data.in_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_greater;

      if (i == 0) begin : g_top
         // Above the top cell there is nothing, which acts like a larger level.
         assign prev_entry   = ctrl.new_entry;
         assign prev_greater = 1'b1;
      end else begin : g_mid
         assign prev_entry   = cell_entry[i-1];
         assign prev_greater = cell_greater[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign next_entry = '0;
      end else begin : g_upper
         assign next_entry = cell_entry[i+1];
      end

      psq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (COUNT_WIDTH'(i) < count_ff),
         .prev_entry   (prev_entry),
         .prev_greater (prev_greater),
         .next_entry   (next_entry),
         .entry        (cell_entry[i]),
         .greater      (cell_greater[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (req_data.op == OP_PUSH) begin
         rsp_in.status = full ? ST_OVERFLOW : ST_PUSHED;
      end else if (empty) begin
         rsp_in.status = ST_UNDERFLOW;
      end else begin
         rsp_in.status       = ST_POPPED;
         rsp_in.out_id       = cell_entry[0].id;
         rsp_in.out_priority = cell_entry[0].level;
      end
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count exceeds depth");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without accepted word");

   a_overflow_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_PUSH && full) |=> $stable(count_ff))
      else $error("overflowing push changed the fill count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_UNDERFLOW || rsp_data.status == ST_OVERFLOW
         || rsp_data.status == ST_PUSHED)) |-> (rsp_data.out_id == '0
         && rsp_data.out_priority == '0))
      else $error("non-pop response carries entry data");
`endif

endmodule
